// ===== design/cts_pkg.sv =====
`default_nettype none

package cts_pkg;

  // Fixed point format of the payload: probabilities carry one integer bit.
  localparam int FRAC_BITS = 16;
  localparam int PROB_W    = FRAC_BITS + 1;
  localparam int UNI_W     = FRAC_BITS;

  localparam int IDX_W     = 8;   // row and column fields of a beat
  localparam int CNT_W     = 9;   // rows_in_use, columns_in_use, outcome
  localparam int STATUS_W  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MODE     = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic MODE_COUNTER = 1'b0;
  localparam logic MODE_FIELD   = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_COLUMN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_OUTCOME = 2'd2;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  column;
    logic [PROB_W-1:0] probability;
    logic [UNI_W-1:0]  uniform;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]    outcome;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

`default_nettype wire

// ===== design/cts_ram.sv =====
`default_nettype none

module cts_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/categorical_table_sampler.sv =====
// A load beat writes its entry on acceptance and gives no result. A sample beat walks
// the rows of its column and registers its result when a row hits or the rows run out;
// a bad column or zero rows answers in the cycle after acceptance. Throughput is one
// table read per cycle on the single read port; busy holds off beats until a walk ends.
// Reset (rst_n low, synchronous) clears control and the column counter and restores the
// registers to their defaults; the table is undefined until loaded. No result stalls.
`default_nettype none

module categorical_table_sampler #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cts_pkg::in_t                    in_data,
  // result channel
  output logic                                 out_valid,
  output cts_pkg::out_t                        out_data,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [cts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [cts_pkg::CNT_W-1:0] rows_r, rows_nxt;
  logic [cts_pkg::CNT_W-1:0] cols_r, cols_nxt;
  logic                      mode_r, mode_nxt;

  // Control and walk state
  cts_pkg::state_t            state_r, state_nxt;
  logic [cts_pkg::IDX_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [cts_pkg::CNT_W-1:0]  k_r, k_nxt;
  logic [cts_pkg::UNI_W-1:0]  rem_r, rem_nxt;
  logic [AW-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cts_pkg::out_t              out_data_r, out_data_nxt;

  // Table memory port
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [cts_pkg::PROB_W-1:0] ram_rdata;

  // Helpers
  logic [cts_pkg::CNT_W-1:0]  eff_rows;
  logic [cts_pkg::CNT_W-1:0]  eff_cols;
  logic                       accept;
  logic                       is_load;
  logic [cts_pkg::IDX_W-1:0]  sel_col;
  logic                       col_ok;
  logic [cts_pkg::CNT_W-1:0]  col_plus1;
  logic [cts_pkg::CNT_W-1:0]  k_plus1;
  logic [AW-1:0]              base_addr;
  logic                       hit;

  cts_ram #(
    .WIDTH (cts_pkg::PROB_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.probability),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    // Clamp the programmed sizes to what the store holds.
    eff_rows = (32'(rows_r) > MAX_ROWS) ? cts_pkg::CNT_W'(MAX_ROWS) : rows_r;
    eff_cols = (32'(cols_r) > MAX_COLS) ? cts_pkg::CNT_W'(MAX_COLS) : cols_r;

    accept  = start && (state_r == cts_pkg::ST_IDLE);
    is_load = (in_data.command == cts_pkg::CMD_LOAD);

    sel_col   = (mode_r == cts_pkg::MODE_FIELD) ? in_data.column : col_cnt_r;
    col_ok    = {1'b0, sel_col} < eff_cols;
    col_plus1 = {1'b0, sel_col} + 9'd1;
    k_plus1   = k_r + 9'd1;

    // Entry (row, column) sits at column*MAX_ROWS + row.
    base_addr = AW'(32'(sel_col) * 32'(MAX_ROWS));
    ram_waddr = AW'(32'(in_data.column) * 32'(MAX_ROWS) + 32'(in_data.row));
    ram_we    = accept && is_load && (32'(in_data.row) < MAX_ROWS)
                && (32'(in_data.column) < MAX_COLS);

    // Issue row 0 on the accept cycle, then stream one row ahead each walk cycle.
    ram_raddr = (state_r == cts_pkg::ST_IDLE) ? base_addr : rd_ptr_r;

    hit = ({1'b0, rem_r} <= ram_rdata);

    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    mode_nxt      = mode_r;
    state_nxt     = state_r;
    col_cnt_nxt   = col_cnt_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      case (cfg_index)
        cts_pkg::CFG_ROWS_IN_USE:    rows_nxt = cfg_wdata;
        cts_pkg::CFG_COLUMNS_IN_USE: cols_nxt = cfg_wdata;
        cts_pkg::CFG_INDEX_MODE:     mode_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      cts_pkg::ST_IDLE: begin
        if (accept && !is_load) begin
          // Advance the running column; an out-of-range counter restarts at zero.
          if (mode_r == cts_pkg::MODE_COUNTER) begin
            if (!col_ok || (col_plus1 >= eff_cols)) begin
              col_cnt_nxt = '0;
            end else begin
              col_cnt_nxt = col_plus1[cts_pkg::IDX_W-1:0];
            end
          end
          if (!col_ok) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.outcome = '0;
            out_data_nxt.status  = cts_pkg::STATUS_BAD_COLUMN;
          end else if (eff_rows == '0) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.outcome = '0;
            out_data_nxt.status  = cts_pkg::STATUS_NO_OUTCOME;
          end else begin
            state_nxt  = cts_pkg::ST_WALK;
            k_nxt      = '0;
            rem_nxt    = in_data.uniform;
            rd_ptr_nxt = base_addr + AW'(1);
          end
        end
      end
      cts_pkg::ST_WALK: begin
        // ram_rdata holds row k_r of the chosen column.
        rd_ptr_nxt = rd_ptr_r + AW'(1);
        if (hit) begin
          state_nxt            = cts_pkg::ST_IDLE;
          out_valid_nxt        = 1'b1;
          out_data_nxt.outcome = k_plus1;
          out_data_nxt.status  = cts_pkg::STATUS_OK;
        end else begin
          // Entry is below the remainder here, so the difference fits.
          rem_nxt = rem_r - ram_rdata[cts_pkg::UNI_W-1:0];
          if (k_plus1 >= eff_rows) begin
            state_nxt            = cts_pkg::ST_IDLE;
            out_valid_nxt        = 1'b1;
            out_data_nxt.outcome = '0;
            out_data_nxt.status  = cts_pkg::STATUS_NO_OUTCOME;
          end else begin
            k_nxt = k_plus1;
          end
        end
      end
      default: state_nxt = cts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= 9'd256;
      cols_r      <= 9'd256;
      mode_r      <= cts_pkg::MODE_FIELD;
      state_r     <= cts_pkg::ST_IDLE;
      col_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      mode_r      <= mode_nxt;
      state_r     <= state_nxt;
      col_cnt_r   <= col_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != cts_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
